// ===== hw/rtl/ubfp_pkg.sv =====
package ubfp_pkg;

  // configuration register indexes (byte address is 4 * index)
  localparam logic [2:0] REG_MAX_FRAMES   = 3'd0;
  localparam logic [2:0] REG_MAX_BYTES    = 3'd1;
  localparam logic [2:0] REG_MAX_AGE      = 3'd2;
  localparam logic [2:0] REG_INTERVAL     = 3'd3;
  localparam logic [2:0] REG_PER_DAY      = 3'd4;
  localparam logic [2:0] REG_BURST_LIMIT  = 3'd5;
  localparam logic [2:0] REG_BURST_WINDOW = 3'd6;
  localparam logic [2:0] REG_DRIFT_URGENT = 3'd7;

  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;

  // register reset values
  localparam logic [7:0]  RST_MAX_FRAMES   = 8'd12;
  localparam logic [15:0] RST_MAX_BYTES    = 16'd11000;
  localparam logic [31:0] RST_MAX_AGE      = 32'd604800;
  localparam logic [31:0] RST_INTERVAL     = 32'd259200;
  localparam logic [7:0]  RST_PER_DAY      = 8'd2;
  localparam logic [7:0]  RST_BURST_LIMIT  = 8'd3;
  localparam logic [31:0] RST_BURST_WINDOW = 32'd172800;
  localparam logic        RST_DRIFT_URGENT = 1'b0;

  // urgency kinds
  localparam logic [1:0] KIND_NONE  = 2'd0;
  localparam logic [1:0] KIND_STEP  = 2'd1;
  localparam logic [1:0] KIND_DRIFT = 2'd2;

  // day number = now / 86400 = (now >> 7) / 675, done as a reciprocal multiply
  // exact for all 25-bit dividends: 50903317 * 675 - 2^35 = 607 <= 2^10
  localparam int          DAY_SHIFT   = 7;
  localparam int          DAY_NUM_W   = 32 - DAY_SHIFT;
  localparam int          DAY_RECIP_W = 26;
  localparam logic [25:0] DAY_RECIP   = 26'd50903317;
  localparam int          DAY_FRAC    = 35;
  localparam int          DAY_PROD_W  = DAY_NUM_W + DAY_RECIP_W;
  localparam int          DAY_W       = 16;

  typedef struct packed {
    logic [7:0]  max_batch_frames;
    logic [15:0] max_batch_bytes;
    logic [31:0] max_batch_age;
    logic [31:0] connect_interval;
    logic [7:0]  connects_per_day;
    logic [7:0]  burst_limit;
    logic [31:0] burst_window;
    logic        drift_is_urgent;
  } ubfp_cfg_t;

endpackage

// ===== hw/rtl/upload_batch_flush_policy_top.sv =====
// channel   direction  handshake          payload
// in_       input      in_valid/in_stall   now_seconds, upload_length, urgency_kind
// out_      output     out_valid/out_stall was_queued, evicted_oldest, was_rejected,
//                                          connect_now, flushed_bytes, flushed_frames,
//                                          drop_total
// cfg_      apb slave  psel/penable/pready registers 0..7 at byte address 4*index
//
// each item passes three steps: transfer and ring head read, queue update with memory
// write, connect decision into the output register
// the day number comes from a registered reciprocal multiply started at transfer
// a stalled result holds the block in the decision step until it is taken
// reset is synchronous; the ring memories are not cleared, only entries inside
// the ring are ever used
module upload_batch_flush_policy_top
  import ubfp_pkg::*;
#(
  parameter int QUEUE_SLOTS    = 16,
  parameter int SLOT_BYTES     = 1024,
  parameter int PRIORITY_EXTRA = 1
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [31:0]           in_now_seconds,
  input  logic [15:0]           in_upload_length,
  input  logic [1:0]            in_urgency_kind,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_was_queued,
  output logic                  out_evicted_oldest,
  output logic                  out_was_rejected,
  output logic                  out_connect_now,
  output logic [15:0]           out_flushed_bytes,
  output logic [7:0]            out_flushed_frames,
  output logic [31:0]           out_drop_total,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  localparam int AW  = $clog2(QUEUE_SLOTS);
  localparam int CW  = $clog2(QUEUE_SLOTS + 1);
  localparam int BTW = $clog2(QUEUE_SLOTS * SLOT_BYTES + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_UPD  = 2'd1;
  localparam logic [1:0] ST_DEC  = 2'd2;

  ubfp_cfg_t cfg;

  ubfp_cfg_regs u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  // ring storage
  logic [15:0] mem_len  [QUEUE_SLOTS];
  logic [31:0] mem_time [QUEUE_SLOTS];

  // control and policy state
  logic [1:0]            state_r, state_nxt;
  logic [AW-1:0]         head_r, head_nxt;
  logic [CW-1:0]         count_r, count_nxt;
  logic [BTW-1:0]        bytes_r, bytes_nxt;
  logic [31:0]           dropped_r, dropped_nxt;
  logic [DAY_W-1:0]      day_r, day_nxt;
  logic [7:0]            conn_today_r, conn_today_nxt;
  logic [31:0]           burst_start_r, burst_start_nxt;
  logic [7:0]            burst_taken_r, burst_taken_nxt;
  logic [31:0]           last_conn_r, last_conn_nxt;
  logic [31:0]           conn_total_r, conn_total_nxt;
  logic                  out_valid_r, out_valid_nxt;

  // item registers
  logic [31:0]           t_r;
  logic [15:0]           len_r;
  logic [1:0]            kind_r;
  logic [DAY_PROD_W-1:0] prod_r;
  logic [15:0]           rd_len_r;
  logic [31:0]           rd_time_r;
  logic [31:0]           oldest_r;
  logic                  queued_r, evicted_r, rejected_r;

  // output payload
  logic                  o_queued_r;
  logic                  o_evicted_r;
  logic                  o_rejected_r;
  logic                  o_conn_r;
  logic [15:0]           o_fbytes_r;
  logic [7:0]            o_fframes_r;
  logic [31:0]           o_drop_r;

  logic                  in_acc;
  logic                  out_free;

  // update step signals
  logic                  upd_valid_len;
  logic                  upd_reject;
  logic                  upd_evict;
  logic [AW-1:0]         upd_head;
  logic [CW-1:0]         upd_count;
  logic [BTW-1:0]        upd_bytes;
  logic [CW:0]           slot_sum;
  logic [AW-1:0]         upd_slot;
  logic                  upd_write;

  // decision step signals
  logic [DAY_W-1:0]      day_now;
  logic [7:0]            ct_eff;
  logic                  ring_busy;
  logic                  hard_hit;
  logic                  urgent;
  logic                  burst_expire;
  logic [7:0]            bu_eff;
  logic [7:0]            urgent_budget;
  logic                  urgent_ok;
  logic                  sched_hit;
  logic                  conn;

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  // queue update: reject, evict, then append at head + count
  always_comb begin
    upd_valid_len = (len_r != 16'd0);
    upd_reject    = upd_valid_len && (32'(len_r) > 32'(SLOT_BYTES));
    upd_evict     = upd_valid_len && !upd_reject && (32'(count_r) >= 32'(QUEUE_SLOTS));
    upd_head      = head_r;
    upd_count     = count_r;
    upd_bytes     = bytes_r;
    if (upd_evict) begin
      upd_head  = (32'(head_r) == 32'(QUEUE_SLOTS - 1)) ? '0 : head_r + AW'(1);
      upd_count = count_r - CW'(1);
      upd_bytes = bytes_r - BTW'(rd_len_r);
    end
    slot_sum = (CW + 1)'(upd_head) + (CW + 1)'(upd_count);
    if (32'(slot_sum) >= 32'(QUEUE_SLOTS)) begin
      slot_sum = slot_sum - (CW + 1)'(QUEUE_SLOTS);
    end
    upd_slot  = slot_sum[AW-1:0];
    upd_write = upd_valid_len && !upd_reject;
    if (upd_write) begin
      upd_count = upd_count + CW'(1);
      upd_bytes = upd_bytes + BTW'(len_r);
    end
  end

  // connect decision on the updated ring
  always_comb begin
    day_now       = prod_r[DAY_FRAC +: DAY_W];
    ct_eff        = (day_r != day_now) ? 8'd0 : conn_today_r;
    ring_busy     = (count_r != '0);
    hard_hit      = (32'(count_r) >= 32'(cfg.max_batch_frames)) ||
                    (32'(bytes_r) >= 32'(cfg.max_batch_bytes)) ||
                    (32'(count_r) >= 32'(QUEUE_SLOTS - 1));
    urgent        = (kind_r == KIND_STEP) ||
                    ((kind_r == KIND_DRIFT) && cfg.drift_is_urgent);
    burst_expire  = (t_r - burst_start_r) > cfg.burst_window;
    bu_eff        = burst_expire ? 8'd0 : burst_taken_r;
    urgent_budget = cfg.connects_per_day + 8'(PRIORITY_EXTRA);
    urgent_ok     = urgent && (bu_eff < cfg.burst_limit) && (ct_eff < urgent_budget);
    priority if (last_conn_r == 32'd0) begin
      sched_hit = (t_r - oldest_r) >= cfg.connect_interval;
    end else if ((t_r - last_conn_r) >= cfg.connect_interval) begin
      sched_hit = ct_eff < cfg.connects_per_day;
    end else begin
      sched_hit = (t_r - oldest_r) >= cfg.max_batch_age;
    end
    conn = ring_busy && (hard_hit || urgent_ok || sched_hit);
  end

  // next state
  always_comb begin
    state_nxt       = state_r;
    head_nxt        = head_r;
    count_nxt       = count_r;
    bytes_nxt       = bytes_r;
    dropped_nxt     = dropped_r;
    day_nxt         = day_r;
    conn_today_nxt  = conn_today_r;
    burst_start_nxt = burst_start_r;
    burst_taken_nxt = burst_taken_r;
    last_conn_nxt   = last_conn_r;
    conn_total_nxt  = conn_total_r;
    out_valid_nxt   = out_valid_r && out_stall;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = ST_UPD;
        end
      end
      ST_UPD: begin
        head_nxt  = upd_head;
        count_nxt = upd_count;
        bytes_nxt = upd_bytes;
        if (upd_reject || upd_evict) begin
          dropped_nxt = dropped_r + 32'd1;
        end
        state_nxt = ST_DEC;
      end
      ST_DEC: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
          if (ring_busy) begin
            day_nxt        = day_now;
            conn_today_nxt = ct_eff;
            if (!hard_hit && urgent) begin
              burst_start_nxt = burst_expire ? t_r : burst_start_r;
              burst_taken_nxt = urgent_ok ? bu_eff + 8'd1 : bu_eff;
            end
          end
          if (conn) begin
            conn_today_nxt = (ct_eff == 8'd255) ? ct_eff : ct_eff + 8'd1;
            conn_total_nxt = conn_total_r + 32'd1;
            last_conn_nxt  = t_r;
            count_nxt      = '0;
            head_nxt       = '0;
            bytes_nxt      = '0;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      head_r        <= '0;
      count_r       <= '0;
      bytes_r       <= '0;
      dropped_r     <= '0;
      day_r         <= '0;
      conn_today_r  <= '0;
      burst_start_r <= '0;
      burst_taken_r <= '0;
      last_conn_r   <= '0;
      conn_total_r  <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      head_r        <= head_nxt;
      count_r       <= count_nxt;
      bytes_r       <= bytes_nxt;
      dropped_r     <= dropped_nxt;
      day_r         <= day_nxt;
      conn_today_r  <= conn_today_nxt;
      burst_start_r <= burst_start_nxt;
      burst_taken_r <= burst_taken_nxt;
      last_conn_r   <= last_conn_nxt;
      conn_total_r  <= conn_total_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  // capture the item and start the day multiply
  always_ff @(posedge clk) begin
    if (in_acc) begin
      t_r    <= in_now_seconds;
      len_r  <= in_upload_length;
      kind_r <= (in_upload_length != 16'd0) ? in_urgency_kind : KIND_NONE;
      prod_r <= DAY_PROD_W'(in_now_seconds[31:DAY_SHIFT]) * DAY_PROD_W'(DAY_RECIP);
    end
  end

  // oldest entry time, forwarded when the ring was empty before this item
  always_ff @(posedge clk) begin
    if (state_r == ST_UPD) begin
      oldest_r   <= (count_r == '0) ? t_r : rd_time_r;
      queued_r   <= upd_write;
      evicted_r  <= upd_evict;
      rejected_r <= upd_reject;
    end
  end

  // length memory: head read at transfer, append write in the update step
  always_ff @(posedge clk) begin
    if (state_r == ST_UPD && upd_write) begin
      mem_len[upd_slot] <= len_r;
    end
    if (in_acc) begin
      rd_len_r <= mem_len[head_r];
    end
  end

  // time memory
  always_ff @(posedge clk) begin
    if (state_r == ST_UPD && upd_write) begin
      mem_time[upd_slot] <= t_r;
    end
    if (in_acc) begin
      rd_time_r <= mem_time[head_r];
    end
  end

  // result register, held while the result is stalled
  always_ff @(posedge clk) begin
    if (state_r == ST_DEC && out_free) begin
      o_queued_r   <= queued_r;
      o_evicted_r  <= evicted_r;
      o_rejected_r <= rejected_r;
      o_conn_r     <= conn;
      o_fbytes_r   <= conn ? bytes_r[15:0] : 16'd0;
      o_fframes_r  <= conn ? 8'(count_r) : 8'd0;
      o_drop_r     <= dropped_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_was_queued     = o_queued_r;
  assign out_evicted_oldest = o_evicted_r;
  assign out_was_rejected   = o_rejected_r;
  assign out_connect_now    = o_conn_r;
  assign out_flushed_bytes  = o_fbytes_r;
  assign out_flushed_frames = o_fframes_r;
  assign out_drop_total     = o_drop_r;

endmodule

// ===== hw/rtl/ubfp_cfg_regs.sv =====
module ubfp_cfg_regs
  import ubfp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready,
  output ubfp_cfg_t             cfg
);

  ubfp_cfg_t   cfg_r;
  logic [2:0]  reg_idx;
  logic        wr_en;

  assign reg_idx    = cfg_paddr[4:2];
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;
  assign cfg        = cfg_r;

  // register write on the access phase
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_batch_frames <= RST_MAX_FRAMES;
      cfg_r.max_batch_bytes  <= RST_MAX_BYTES;
      cfg_r.max_batch_age    <= RST_MAX_AGE;
      cfg_r.connect_interval <= RST_INTERVAL;
      cfg_r.connects_per_day <= RST_PER_DAY;
      cfg_r.burst_limit      <= RST_BURST_LIMIT;
      cfg_r.burst_window     <= RST_BURST_WINDOW;
      cfg_r.drift_is_urgent  <= RST_DRIFT_URGENT;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_MAX_FRAMES:   cfg_r.max_batch_frames <= cfg_pwdata[7:0];
        REG_MAX_BYTES:    cfg_r.max_batch_bytes  <= cfg_pwdata[15:0];
        REG_MAX_AGE:      cfg_r.max_batch_age    <= cfg_pwdata;
        REG_INTERVAL:     cfg_r.connect_interval <= cfg_pwdata;
        REG_PER_DAY:      cfg_r.connects_per_day <= cfg_pwdata[7:0];
        REG_BURST_LIMIT:  cfg_r.burst_limit      <= cfg_pwdata[7:0];
        REG_BURST_WINDOW: cfg_r.burst_window     <= cfg_pwdata;
        REG_DRIFT_URGENT: cfg_r.drift_is_urgent  <= cfg_pwdata[0];
        default:          cfg_r                  <= cfg_r;
      endcase
    end
  end

  // read mux
  always_comb begin
    unique case (reg_idx)
      REG_MAX_FRAMES:   cfg_prdata = {24'd0, cfg_r.max_batch_frames};
      REG_MAX_BYTES:    cfg_prdata = {16'd0, cfg_r.max_batch_bytes};
      REG_MAX_AGE:      cfg_prdata = cfg_r.max_batch_age;
      REG_INTERVAL:     cfg_prdata = cfg_r.connect_interval;
      REG_PER_DAY:      cfg_prdata = {24'd0, cfg_r.connects_per_day};
      REG_BURST_LIMIT:  cfg_prdata = {24'd0, cfg_r.burst_limit};
      REG_BURST_WINDOW: cfg_prdata = cfg_r.burst_window;
      REG_DRIFT_URGENT: cfg_prdata = {31'd0, cfg_r.drift_is_urgent};
      default:          cfg_prdata = '0;
    endcase
  end

endmodule
